@@ hw/rtl/dcsl_pkg.sv @@
package dcsl_pkg;

   // Default sizing
   localparam int DCSL_MAX_COLUMNS = 2048;
   localparam int DCSL_MAX_ROWS    = 2048;

   // Fixed field widths
   localparam int PIXEL_W    = 8;
   localparam int ROWS_W     = 11;
   localparam int LEVEL_W    = 8;
   localparam int MIN_DARK_W = 11;
   localparam int MARGIN_W   = 11;
   localparam int STRIPE_W   = 11;
   localparam int USED_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_ROWS      = 3'd0,
      CSR_DARK_MEAN_LIMIT  = 3'd1,
      CSR_BLACK_LEVEL      = 3'd2,
      CSR_MIN_DARK_COLUMNS = 3'd3,
      CSR_TIE_MARGIN       = 3'd4
   } csr_index_type;

   // Frame sequencer
   typedef enum logic [2:0] {
      ST_STREAM,
      ST_DECIDE,
      ST_SCAN,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RESULT
   } state_type;

   // Column close report from the accumulator
   typedef struct packed {
      logic valid;
      logic frame_end;
      logic dark;
   } close_type;

endpackage

@@ hw/rtl/dcsl_ram.sv @@
module dcsl_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/dcsl_div.sv @@
module dcsl_div #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   // One restoring step per cycle, quotient bits shift in from the right
   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(NUM_W);
         quo_in    = numerator;
         rem_in    = '0;
         den_in    = denominator;
      end else if (active_ff) begin
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/dcsl_col_acc.sv @@
module dcsl_col_acc #(
   parameter int MAX_ROWS = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [dcsl_pkg::PIXEL_W-1:0]   pixel,
   input  logic                           last_in_column,
   input  logic                           last_in_frame,
   input  logic [dcsl_pkg::ROWS_W-1:0]    window_rows,
   input  logic [dcsl_pkg::LEVEL_W-1:0]   dark_mean_limit,
   input  logic [dcsl_pkg::LEVEL_W-1:0]   black_level,
   output dcsl_pkg::close_type            close,
   output logic [$clog2(MAX_ROWS)-1:0]    close_count
);

   import dcsl_pkg::*;

   localparam int SUM_W   = $clog2(255 * MAX_ROWS);
   localparam int COUNT_W = $clog2(MAX_ROWS);
   localparam int PROD_W  = LEVEL_W + ROWS_W;
   localparam int CMP_W   = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam logic [SUM_W-1:0]   SUM_CAP   = SUM_W'(255 * (MAX_ROWS - 1));
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(MAX_ROWS - 1);

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               close_valid_ff, close_valid_in;
   logic               close_frame_ff, close_frame_in;
   logic [SUM_W-1:0]   close_sum_ff, close_sum_in;
   logic [COUNT_W-1:0] close_count_ff, close_count_in;
   logic [SUM_W:0]     sum_ext;
   logic [SUM_W-1:0]   sum_next;
   logic [COUNT_W-1:0] count_next;
   logic [PROD_W-1:0]  limit_prod;

   // Running column totals with saturation
   always_comb begin
      sum_ext  = {1'b0, sum_ff} + (SUM_W + 1)'(pixel);
      sum_next = (sum_ext > {1'b0, SUM_CAP}) ? SUM_CAP : sum_ext[SUM_W-1:0];
      count_next = count_ff;
      if (pixel <= black_level && count_ff < COUNT_CAP) begin
         count_next = count_ff + COUNT_W'(1);
      end
   end

   always_comb begin
      sum_in         = sum_ff;
      count_in       = count_ff;
      close_valid_in = 1'b0;
      close_frame_in = close_frame_ff;
      close_sum_in   = close_sum_ff;
      close_count_in = close_count_ff;
      if (accept) begin
         if (last_in_column || last_in_frame) begin
            sum_in         = '0;
            count_in       = '0;
            close_valid_in = 1'b1;
            close_frame_in = last_in_frame;
            close_sum_in   = sum_next;
            close_count_in = count_next;
         end else begin
            sum_in   = sum_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff         <= '0;
         count_ff       <= '0;
         close_valid_ff <= 1'b0;
         close_frame_ff <= 1'b0;
      end else begin
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         close_valid_ff <= close_valid_in;
         close_frame_ff <= close_frame_in;
      end
      close_sum_ff   <= close_sum_in;
      close_count_ff <= close_count_in;
   end

   // Dark test: floor(sum / rows) < limit  <=>  sum < limit * rows
   assign limit_prod = PROD_W'(dark_mean_limit) * PROD_W'(window_rows);

   always_comb begin
      close.valid     = close_valid_ff;
      close.frame_end = close_frame_ff;
      close.dark      = (CMP_W'(close_sum_ff) < CMP_W'(limit_prod));
   end

   assign close_count = close_count_ff;

endmodule

@@ hw/rtl/dark_column_stripe_locator.sv @@
// Dark column stripe locator. Pixels of an image band stream in column by
// column, one request per cycle with no stall while a frame is open; columns
// are closed by last_in_column or last_in_frame. The request that ends a frame
// starts the end-of-frame pass, during which req_stall stays high: the last
// column is closed, the mode is chosen, then in fallback mode the per-column
// black-count memory is scanned at one entry per cycle, then the shared
// bit-serial divider runs and the result register is loaded. The scan is
// skipped in mean mode, and the divider is skipped in fallback mode when no
// column is kept. The result register is not loaded while an earlier result
// waits to be taken; it decouples the output: the next frame streams in while
// a result waits to be taken. The memory needs no clearing after reset, as
// only entries written in the current frame are read. Registers are written
// through the csr_ port and should only be changed while no frame is open.
module dark_column_stripe_locator #(
   parameter int MAX_COLUMNS = dcsl_pkg::DCSL_MAX_COLUMNS,
   parameter int MAX_ROWS    = dcsl_pkg::DCSL_MAX_ROWS
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dcsl_pkg::PIXEL_W-1:0]     req_pixel,
   input  logic                             req_last_in_column,
   input  logic                             req_last_in_frame,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dcsl_pkg::STRIPE_W-1:0]    rsp_stripe_column,
   output logic                             rsp_found_by_mean,
   output logic [dcsl_pkg::USED_W-1:0]      rsp_columns_used,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dcsl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dcsl_pkg::CSR_DATA_W-1:0]  csr_data
);

   import dcsl_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_COLUMNS);
   localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
   localparam int NUM_W   = 2 * ADDR_W;
   localparam int COUNT_W = $clog2(MAX_ROWS);
   localparam int DARK_W  = (CNT_W > MIN_DARK_W) ? CNT_W : MIN_DARK_W;
   localparam int KEEP_W  = (COUNT_W > MARGIN_W) ? COUNT_W : MARGIN_W;

   // configuration registers
   logic [ROWS_W-1:0]     window_rows_ff;
   logic [LEVEL_W-1:0]    dark_mean_limit_ff;
   logic [LEVEL_W-1:0]    black_level_ff;
   logic [MIN_DARK_W-1:0] min_dark_ff;
   logic [MARGIN_W-1:0]   tie_margin_ff;

   // frame state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   column_index_ff;
   logic [CNT_W-1:0]   dark_total_ff;
   logic [NUM_W-1:0]   dark_isum_ff;
   logic [COUNT_W-1:0] largest_ff;
   logic               mode_ff;

   // fallback scan
   logic [CNT_W-1:0]   rd_cnt_ff;
   logic               pend_valid_ff;
   logic [ADDR_W-1:0]  pend_idx_ff;
   logic [NUM_W-1:0]   fb_acc_ff;
   logic [CNT_W-1:0]   fb_used_ff;

   // result register
   logic                rsp_valid_ff;
   logic [STRIPE_W-1:0] rsp_stripe_ff;
   logic                rsp_mean_ff;
   logic [USED_W-1:0]   rsp_used_ff;

   logic               req_accept;
   logic               rsp_taken;
   close_type          close;
   logic [COUNT_W-1:0] close_count;
   logic               close_store;
   logic [COUNT_W-1:0] rd_data;
   logic               mean_mode;
   logic               scan_issue;
   logic               scan_done;
   logic               keep;
   logic               div_start;
   logic               div_done;
   logic [NUM_W-1:0]   quotient;
   logic [NUM_W-1:0]   num_sel;
   logic [CNT_W-1:0]   den_sel;
   logic               load_result;
   logic               out_free;

   assign req_accept = req_valid && !req_stall;
   assign rsp_taken  = rsp_valid_ff && !rsp_stall;
   assign csr_ready  = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_rows_ff     <= ROWS_W'(100);
         dark_mean_limit_ff <= LEVEL_W'(10);
         black_level_ff     <= LEVEL_W'(50);
         min_dark_ff        <= MIN_DARK_W'(10);
         tie_margin_ff      <= MARGIN_W'(5);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WINDOW_ROWS:      window_rows_ff     <= csr_data[ROWS_W-1:0];
            CSR_DARK_MEAN_LIMIT:  dark_mean_limit_ff <= csr_data[LEVEL_W-1:0];
            CSR_BLACK_LEVEL:      black_level_ff     <= csr_data[LEVEL_W-1:0];
            CSR_MIN_DARK_COLUMNS: min_dark_ff        <= csr_data[MIN_DARK_W-1:0];
            CSR_TIE_MARGIN:       tie_margin_ff      <= csr_data[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // per-column accumulation
   dcsl_col_acc #(
      .MAX_ROWS (MAX_ROWS)
   ) u_col_acc (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .pixel           (req_pixel),
      .last_in_column  (req_last_in_column),
      .last_in_frame   (req_last_in_frame),
      .window_rows     (window_rows_ff),
      .dark_mean_limit (dark_mean_limit_ff),
      .black_level     (black_level_ff),
      .close           (close),
      .close_count     (close_count)
   );

   // columns past the memory depth are dropped
   assign close_store = close.valid && (column_index_ff < CNT_W'(MAX_COLUMNS));

   dcsl_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_COLUMNS)
   ) u_black_store (
      .clock   (clock),
      .wr_en   (close_store),
      .wr_addr (column_index_ff[ADDR_W-1:0]),
      .wr_data (close_count),
      .rd_en   (scan_issue),
      .rd_addr (rd_cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // mode choice and scan conditions
   assign mean_mode  = (DARK_W'(dark_total_ff) > DARK_W'(min_dark_ff));
   assign scan_issue = (state_ff == ST_SCAN) && (rd_cnt_ff < column_index_ff);
   assign scan_done  = (rd_cnt_ff == column_index_ff) && !pend_valid_ff;
   assign keep       = (KEEP_W'(largest_ff - rd_data) < KEEP_W'(tie_margin_ff));
   assign num_sel    = mode_ff ? dark_isum_ff : fb_acc_ff;
   assign den_sel    = mode_ff ? dark_total_ff : fb_used_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // shared divider for the floor average
   dcsl_div #(
      .NUM_W (NUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num_sel),
      .denominator (den_sel),
      .done        (div_done),
      .quotient    (quotient)
   );

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_STREAM: begin
            if (close.valid && close.frame_end) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = mean_mode ? ST_DIV_GO : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = (fb_used_ff == '0) ? ST_RESULT : ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_STREAM;
            end
         end
         default: state_in = ST_STREAM;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_stall   = 1'b1;
      div_start   = 1'b0;
      load_result = 1'b0;
      unique case (state_ff)
         ST_STREAM:   req_stall = close.valid && close.frame_end;
         ST_DECIDE:   ;
         ST_SCAN:     ;
         ST_DIV_GO:   div_start = 1'b1;
         ST_DIV_WAIT: ;
         ST_RESULT:   load_result = out_free;
         default:     ;
      endcase
   end

   // frame statistics, scan and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_STREAM;
         column_index_ff <= '0;
         dark_total_ff   <= '0;
         dark_isum_ff    <= '0;
         largest_ff      <= '0;
         mode_ff         <= 1'b0;
         rd_cnt_ff       <= '0;
         pend_valid_ff   <= 1'b0;
         fb_acc_ff       <= '0;
         fb_used_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         // column close
         if (close_store) begin
            column_index_ff <= column_index_ff + CNT_W'(1);
            if (close.dark) begin
               dark_total_ff <= dark_total_ff + CNT_W'(1);
               dark_isum_ff  <= dark_isum_ff + NUM_W'(column_index_ff);
            end
            if (close_count > largest_ff) begin
               largest_ff <= close_count;
            end
         end

         // mode latch and scan setup
         if (state_ff == ST_DECIDE) begin
            mode_ff    <= mean_mode;
            rd_cnt_ff  <= '0;
            fb_acc_ff  <= '0;
            fb_used_ff <= '0;
         end

         // fallback scan, memory read data arrives in the cycle after its address
         pend_valid_ff <= scan_issue;
         if (scan_issue) begin
            rd_cnt_ff <= rd_cnt_ff + CNT_W'(1);
         end
         if (pend_valid_ff && keep) begin
            fb_acc_ff  <= fb_acc_ff + NUM_W'(pend_idx_ff);
            fb_used_ff <= fb_used_ff + CNT_W'(1);
         end

         // result hand-off and frame clear
         if (load_result) begin
            rsp_valid_ff    <= 1'b1;
            column_index_ff <= '0;
            dark_total_ff   <= '0;
            dark_isum_ff    <= '0;
            largest_ff      <= '0;
         end else if (rsp_taken) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      pend_idx_ff <= rd_cnt_ff[ADDR_W-1:0];

      if (load_result) begin
         rsp_stripe_ff <= (den_sel == '0) ? '0 : STRIPE_W'(quotient);
         rsp_mean_ff   <= mode_ff;
         rsp_used_ff   <= USED_W'(den_sel);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stripe_column = rsp_stripe_ff;
   assign rsp_found_by_mean = rsp_mean_ff;
   assign rsp_columns_used  = rsp_used_ff;

endmodule

@@ sim/dark_column_stripe_locator_monitor.sv @@
// Watches all three channels of the stripe locator. It keeps its own copy of the
// registers and of the per-frame column totals, works out the frame result when
// a frame closes, and checks every result taken from the block against it.
module dark_column_stripe_locator_monitor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [dcsl_pkg::PIXEL_W-1:0]    req_pixel,
   input  logic                            req_last_in_column,
   input  logic                            req_last_in_frame,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [dcsl_pkg::STRIPE_W-1:0]   rsp_stripe_column,
   input  logic                            rsp_found_by_mean,
   input  logic [dcsl_pkg::USED_W-1:0]     rsp_columns_used,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [dcsl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dcsl_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              failures,
   output int                              results_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   import dcsl_pkg::*;

   localparam int SUM_CAP   = 255 * (DCSL_MAX_ROWS - 1);
   localparam int COUNT_CAP = DCSL_MAX_ROWS - 1;

   typedef struct {
      logic [STRIPE_W-1:0] stripe_column;
      logic                found_by_mean;
      logic [USED_W-1:0]   columns_used;
   } stripe_result_type;

   stripe_result_type stripe_results_due[$];

   // local copy of the registers
   logic [ROWS_W-1:0]     rows_reg;
   logic [LEVEL_W-1:0]    mean_limit_reg;
   logic [LEVEL_W-1:0]    black_level_reg;
   logic [MIN_DARK_W-1:0] min_dark_reg;
   logic [MARGIN_W-1:0]   margin_reg;

   // open column and frame totals
   int column_total;
   int column_blacks;
   int columns_seen;
   int dark_columns;
   int dark_index_total;
   int peak_blacks;
   int blacks_per_column [];

   always @(posedge clock) begin : track
      int                acc;
      int                kept;
      stripe_result_type due;
      if (reset) begin
         rows_reg         = ROWS_W'(100);
         mean_limit_reg   = LEVEL_W'(10);
         black_level_reg  = LEVEL_W'(50);
         min_dark_reg     = MIN_DARK_W'(10);
         margin_reg       = MARGIN_W'(5);
         column_total     = 0;
         column_blacks    = 0;
         columns_seen     = 0;
         dark_columns     = 0;
         dark_index_total = 0;
         peak_blacks      = 0;
         blacks_per_column = new[DCSL_MAX_COLUMNS];
         stripe_results_due.delete();
         failures         = 0;
      end else begin
         // result side: compare with the oldest frame result
         if (rsp_valid && !rsp_stall) begin
            if (stripe_results_due.size() == 0) begin
               $display("%0t ns: result with none due: stripe_column %0d",
                        $time, rsp_stripe_column,
                        " found_by_mean %0d columns_used %0d",
                        rsp_found_by_mean, rsp_columns_used);
               failures++;
            end else begin
               due = stripe_results_due.pop_front();
               if (rsp_stripe_column !== due.stripe_column) begin
                  $display("%0t ns: stripe_column expected %0d, got %0d",
                           $time, due.stripe_column, rsp_stripe_column);
                  failures++;
               end
               if (rsp_found_by_mean !== due.found_by_mean) begin
                  $display("%0t ns: found_by_mean expected %0d, got %0d",
                           $time, due.found_by_mean, rsp_found_by_mean);
                  failures++;
               end
               if (rsp_columns_used !== due.columns_used) begin
                  $display("%0t ns: columns_used expected %0d, got %0d",
                           $time, due.columns_used, rsp_columns_used);
                  failures++;
               end
            end
         end

         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_ROWS:      rows_reg        = csr_data[ROWS_W-1:0];
               CSR_DARK_MEAN_LIMIT:  mean_limit_reg  = csr_data[LEVEL_W-1:0];
               CSR_BLACK_LEVEL:      black_level_reg = csr_data[LEVEL_W-1:0];
               CSR_MIN_DARK_COLUMNS: min_dark_reg    = csr_data[MIN_DARK_W-1:0];
               CSR_TIE_MARGIN:       margin_reg      = csr_data[MARGIN_W-1:0];
               default: ;
            endcase
         end

         // pixel request: accumulate, close column, close frame
         if (req_valid && !req_stall) begin
            column_total += int'(req_pixel);
            if (column_total > SUM_CAP)
               column_total = SUM_CAP;
            if (req_pixel <= black_level_reg && column_blacks < COUNT_CAP)
               column_blacks++;

            if (req_last_in_column || req_last_in_frame) begin
               // columns past the store size are dropped
               if (columns_seen < DCSL_MAX_COLUMNS) begin
                  blacks_per_column[columns_seen] = column_blacks;
                  if (column_total < int'(mean_limit_reg) * int'(rows_reg)) begin
                     dark_columns++;
                     dark_index_total += columns_seen;
                  end
                  if (column_blacks > peak_blacks)
                     peak_blacks = column_blacks;
                  columns_seen++;
               end
               column_total  = 0;
               column_blacks = 0;
            end

            if (req_last_in_frame) begin
               if (dark_columns > int'(min_dark_reg)) begin
                  due.found_by_mean = 1'b1;
                  due.columns_used  = USED_W'(dark_columns);
                  due.stripe_column = STRIPE_W'(dark_index_total / dark_columns);
               end else begin
                  // fallback: columns whose black count is near the peak
                  acc  = 0;
                  kept = 0;
                  for (int i = 0; i < columns_seen; i++) begin
                     if (peak_blacks - blacks_per_column[i] < int'(margin_reg)) begin
                        acc += i;
                        kept++;
                     end
                  end
                  due.found_by_mean = 1'b0;
                  due.columns_used  = USED_W'(kept);
                  due.stripe_column = (kept != 0) ? STRIPE_W'(acc / kept) : '0;
               end
               stripe_results_due.insert(stripe_results_due.size(), due);
               columns_seen     = 0;
               dark_columns     = 0;
               dark_index_total = 0;
               peak_blacks      = 0;
            end
         end
      end
      results_waiting = stripe_results_due.size();
   end

endmodule

@@ sim/dark_column_stripe_locator_test.sv @@
module dark_column_stripe_locator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dcsl_pkg::*;

   localparam int RANDOM_ITEMS  = 700;
   localparam int SETTLE_CYCLES = 64;
   localparam int QUIET_LIMIT   = 10000;

   typedef struct {
      int rows;
      int limit;
      int black;
      int min_dark;
      int margin;
   } band_settings_type;

   logic                  clock;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic [PIXEL_W-1:0]    req_pixel          = '0;
   logic                  req_last_in_column = 1'b0;
   logic                  req_last_in_frame  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic [STRIPE_W-1:0]   rsp_stripe_column;
   logic                  rsp_found_by_mean;
   logic [USED_W-1:0]     rsp_columns_used;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index          = CSR_WINDOW_ROWS;
   logic [CSR_DATA_W-1:0] csr_data           = '0;
   int                    failures;
   int                    results_waiting;

   band_settings_type band;
   bit             calm        = 1'b0;
   bit             req_gaps_on = 1'b1;
   int             pixels_sent = 0;
   int             stall_run   = 0;
   int             quiet_cycles = 0;

   dark_column_stripe_locator dut (.*);

   dark_column_stripe_locator_monitor stripe_monitor (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result side back-pressure in runs of random length
   always @(negedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_run > 0) begin
         stall_run = stall_run - 1;
      end else begin
         stall_run = $urandom_range(0, 15);
         rsp_stall <= ($urandom_range(0, 2) == 0);
      end
   end

   // give up when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("dark_column_stripe_locator regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one pixel request, with an occasional idle burst in front of it
   task automatic push_pixel(input int pixel, input bit end_column, input bit end_frame);
      int gap;
      if (req_gaps_on && !calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_pixel          <= PIXEL_W'(pixel);
      req_last_in_column <= end_column;
      req_last_in_frame  <= end_frame;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic write_register(input csr_index_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // wait for the block to drain, then write every register from band
   task automatic load_registers();
      req_valid <= 1'b0;
      while (results_waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_register(CSR_WINDOW_ROWS, band.rows);
      write_register(CSR_DARK_MEAN_LIMIT, band.limit);
      write_register(CSR_BLACK_LEVEL, band.black);
      write_register(CSR_MIN_DARK_COLUMNS, band.min_dark);
      write_register(CSR_TIE_MARGIN, band.margin);
      csr_valid <= 1'b0;
   endtask

   // random settings, extremes given a fair share
   task automatic pick_settings();
      case ($urandom_range(0, 7))
         0:       band.rows = 0;
         1:       band.rows = 2047;
         2:       band.rows = 1;
         default: band.rows = $urandom_range(2, 8);
      endcase
      case ($urandom_range(0, 5))
         0:       band.limit = 0;
         1:       band.limit = 255;
         default: band.limit = $urandom_range(1, 254);
      endcase
      case ($urandom_range(0, 5))
         0:       band.black = 0;
         1:       band.black = 255;
         default: band.black = $urandom_range(1, 254);
      endcase
      case ($urandom_range(0, 5))
         0:       band.min_dark = 0;
         1:       band.min_dark = 2047;
         default: band.min_dark = $urandom_range(0, 6);
      endcase
      case ($urandom_range(0, 5))
         0:       band.margin = 0;
         1:       band.margin = 2047;
         2:       band.margin = 1;
         default: band.margin = $urandom_range(0, 4);
      endcase
   endtask

   // A well-formed frame has columns of mostly equal length (window_rows when
   // that is 1 to 12) with a style per column; a noisy one has random pixels and random column ends.
   task automatic send_frame(input int span, input bit noisy);
      int rows_per;
      int col_len;
      int kind;
      int pixel;
      bit close_col;
      rows_per = (band.rows >= 1 && band.rows <= 12) ? band.rows : $urandom_range(1, 6);
      if (noisy) begin
         for (int i = 0; i < span; i++)
            push_pixel($urandom_range(0, 255), $urandom_range(0, 3) == 0, i == span - 1);
      end else begin
         for (int c = 0; c < span; c++) begin
            col_len = ($urandom_range(0, 11) == 0) ? $urandom_range(1, rows_per + 3) : rows_per;
            kind    = $urandom_range(0, 3);
            for (int r = 0; r < col_len; r++) begin
               case (kind)
                  0:       pixel = (band.limit > 0) ? $urandom_range(0, band.limit - 1) : 0;
                  1:       pixel = $urandom_range(0, band.black);
                  2:       pixel = $urandom_range(band.black, 255);
                  default: pixel = $urandom_range(0, 255);
               endcase
               close_col = (r == col_len - 1);
               // the closing request may or may not also mark the column end
               if (close_col && c == span - 1)
                  push_pixel(pixel, $urandom_range(0, 1), 1'b1);
               else
                  push_pixel(pixel, close_col, 1'b0);
            end
         end
      end
   endtask

   initial begin : stimulus
      int first_random;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: a lone dark pixel, then a lone bright one
      push_pixel(0, 1'b0, 1'b1);
      push_pixel(255, 1'b0, 1'b1);

      // two-row columns, all dark, mean mode with no minimum
      band = '{2, 255, 0, 0, 2047};
      load_registers();
      push_pixel(0, 1'b0, 1'b0);
      push_pixel(255, 1'b1, 1'b0);
      push_pixel(254, 1'b0, 1'b0);
      push_pixel(1, 1'b1, 1'b0);
      push_pixel(128, 1'b0, 1'b0);
      push_pixel(127, 1'b1, 1'b1);

      // zero window rows and zero tie margin: no column kept
      band = '{0, 0, 255, 2047, 0};
      load_registers();
      push_pixel(0, 1'b1, 1'b0);
      push_pixel(255, 1'b0, 1'b1);

      // dark columns below the minimum: fallback on the peak black count
      band = '{2047, 255, 255, 2047, 1};
      load_registers();
      push_pixel(17, 1'b1, 1'b0);
      push_pixel(200, 1'b0, 1'b0);
      push_pixel(3, 1'b0, 1'b1);

      // random phases of a few frames under one setting each
      first_random = pixels_sent;
      while (pixels_sent - first_random < RANDOM_ITEMS) begin
         pick_settings();
         load_registers();
         repeat ($urandom_range(1, 4)) begin
            req_gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
               send_frame($urandom_range(1, 30), 1'b1);
            else
               send_frame($urandom_range(1, 24), 1'b0);
         end
      end

      // closing stretch with no idling on either side
      calm        = 1'b1;
      req_gaps_on = 1'b0;
      repeat (3) begin
         pick_settings();
         load_registers();
         repeat (2) send_frame($urandom_range(4, 20), 1'b0);
      end

      req_valid <= 1'b0;
      while (results_waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("dark_column_stripe_locator regression: pass");
      else
         $display("dark_column_stripe_locator regression: fail");
      $finish;
   end

endmodule
